[rtl/nct_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// nct_pkg
// Shared types and constants for the normalization cube map texel generator.
// ----------------------------------------------------------------------------
package nct_pkg;

	// default largest face edge in texels
	localparam int unsigned MAX_EDGE_DEF = 1024;

	// face edge after reset
	localparam logic [10:0] EDGE_RST = 11'd64;

	// cube face selector codes
	localparam logic [2:0] FACE_POS_X = 3'd0;
	localparam logic [2:0] FACE_NEG_X = 3'd1;
	localparam logic [2:0] FACE_POS_Y = 3'd2;
	localparam logic [2:0] FACE_NEG_Y = 3'd3;
	localparam logic [2:0] FACE_POS_Z = 3'd4;
	localparam logic [2:0] FACE_NEG_Z = 3'd5;

	// alpha byte of every texel
	localparam logic [7:0] ALPHA_ONE = 8'hff;

	typedef struct packed {
		logic [2:0] cube_face;
		logic [9:0] texel_col;
		logic [9:0] texel_row;
	} texel_req_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
	} texel_rgba_t;

endpackage
`default_nettype wire

[rtl/nct_dly.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// nct_dly
// Fixed-depth delay line that carries valid bits and sideband data alongside
// a pipelined arithmetic unit.
// ----------------------------------------------------------------------------
module nct_dly #(
	parameter int unsigned W     = 8,
	parameter int unsigned DEPTH = 4
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic [W-1:0] d,
	output logic      [W-1:0] q
);

	logic [W-1:0] tap_s [0:DEPTH-1];

	// shift every stage one place each cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) begin
				tap_s[i] <= '0;
			end
		end else begin
			tap_s[0] <= d;
			for (int i = 1; i < DEPTH; i++) begin
				tap_s[i] <= tap_s[i-1];
			end
		end
	end

	assign q = tap_s[DEPTH-1];

endmodule
`default_nettype wire

[rtl/nct_div.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// nct_div
// Pipelined restoring divider, one quotient bit per stage. The upper
// numerator bits above the quotient field must be below the divisor.
// ----------------------------------------------------------------------------
module nct_div #(
	parameter int unsigned NW = 27,
	parameter int unsigned DW = 11,
	parameter int unsigned QW = 18
) (
	input  wire logic          clk,
	input  wire logic [NW-1:0] num,
	input  wire logic [DW-1:0] den,
	output logic      [QW-1:0] quo
);

	logic [DW-1:0] rem_s [0:QW-1];
	logic [QW-1:0] low_s [0:QW-1];
	logic [QW-1:0] quo_s [0:QW-1];
	logic [DW-1:0] den_s [0:QW-1];

	for (genvar k = 0; k < QW; k++) begin : g_stage
		logic [DW-1:0] rem_p;
		logic [QW-1:0] low_p;
		logic [QW-1:0] quo_p;
		logic [DW-1:0] den_p;
		logic [DW:0]   part;
		logic          ge;

		// pick the previous stage, or the operands at the head
		if (k == 0) begin : g_head
			assign rem_p = DW'(num[NW-1:QW]);
			assign low_p = num[QW-1:0];
			assign quo_p = '0;
			assign den_p = den;
		end else begin : g_body
			assign rem_p = rem_s[k-1];
			assign low_p = low_s[k-1];
			assign quo_p = quo_s[k-1];
			assign den_p = den_s[k-1];
		end

		// bring down one numerator bit and try the subtract
		assign part = {rem_p, low_p[QW-1]};
		assign ge   = part >= {1'b0, den_p};

		always_ff @(posedge clk) begin
			rem_s[k] <= ge ? DW'(part - {1'b0, den_p}) : DW'(part);
			low_s[k] <= low_p << 1;
			quo_s[k] <= {quo_p[QW-2:0], ge};
			den_s[k] <= den_p;
		end
	end

	assign quo = quo_s[QW-1];

endmodule
`default_nettype wire

[rtl/nct_sqrt.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// nct_sqrt
// Pipelined integer square root (floor), one result bit per stage using the
// digit-by-digit method.
// ----------------------------------------------------------------------------
module nct_sqrt #(
	parameter int unsigned LW = 34,
	localparam int unsigned RW = LW / 2
) (
	input  wire logic          clk,
	input  wire logic [LW-1:0] rad,
	output logic      [RW-1:0] root
);

	logic [RW+1:0] rem_s  [0:RW-1];
	logic [RW-1:0] root_s [0:RW-1];
	logic [LW-1:0] rad_s  [0:RW-1];

	for (genvar k = 0; k < RW; k++) begin : g_stage
		logic [RW+1:0] rem_p;
		logic [RW-1:0] root_p;
		logic [LW-1:0] rad_p;
		logic [RW+3:0] cand;
		logic [RW+3:0] trial;
		logic          ge;

		if (k == 0) begin : g_head
			assign rem_p  = '0;
			assign root_p = '0;
			assign rad_p  = rad;
		end else begin : g_body
			assign rem_p  = rem_s[k-1];
			assign root_p = root_s[k-1];
			assign rad_p  = rad_s[k-1];
		end

		// bring down the next bit pair and try root*4+1
		assign cand  = {rem_p, rad_p[LW-1:LW-2]};
		assign trial = {2'b00, root_p, 2'b01};
		assign ge    = cand >= trial;

		always_ff @(posedge clk) begin
			rem_s[k]  <= ge ? (RW+2)'(cand - trial) : (RW+2)'(cand);
			root_s[k] <= {root_p[RW-2:0], ge};
			rad_s[k]  <= rad_p << 2;
		end
	end

	assign root = root_s[RW-1];

endmodule
`default_nettype wire

[rtl/normalization_cubemap_texel.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// normalization_cubemap_texel
// Computes one RGBA8 texel of a normalization cube map per request.
// ----------------------------------------------------------------------------
// Throughput: one texel per clock; busy is never raised. The rate is set by
//   the bit-per-stage pipelines of the two coordinate dividers, the square
//   root and the reciprocal divider.
// Reset: clears all valid bits and sets face_edge to 64.
// Results are strobed on done for one cycle; the receiver cannot stall.
module normalization_cubemap_texel #(
	parameter int unsigned MAX_EDGE = nct_pkg::MAX_EDGE_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire nct_pkg::texel_req_t req,
	output logic                    done,
	output nct_pkg::texel_rgba_t    result,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [10:0]        cfg_data
);

	localparam int unsigned EW     = $clog2(MAX_EDGE + 1);
	localparam int unsigned DIV_NW = 27;
	localparam int unsigned DIV_QW = 18;
	localparam int unsigned SQ_LW  = 34;
	localparam int unsigned SQ_RW  = SQ_LW / 2;
	localparam int unsigned RCP_NW = 47;
	localparam int unsigned RCP_QW = 31;
	localparam int unsigned SB_W   = 1 + 3 + 3 * 17;

	logic [10:0] face_edge_q;
	logic [EW-1:0] edge_c;
	logic [9:0] col_c;
	logic [9:0] row_c;

	logic                  valid_s1;
	logic [2:0]            face_s1;
	logic [DIV_NW-1:0]     num_u_s1;
	logic [DIV_NW-1:0]     num_v_s1;

	logic [DIV_QW-1:0]     t_u;
	logic [DIV_QW-1:0]     t_v;
	logic                  div_valid;
	logic [2:0]            div_face;

	logic signed [18:0]    u;
	logic signed [18:0]    v;
	logic signed [18:0]    dir [0:2];

	logic                  valid_s2;
	logic [2:0]            sgn_s2;
	logic [2:0][16:0]      mag_s2;
	logic                  valid_s3;
	logic [2:0]            sgn_s3;
	logic [2:0][16:0]      mag_s3;
	logic [32:0]           sq_s3 [0:2];
	logic                  valid_s4;
	logic [2:0]            sgn_s4;
	logic [2:0][16:0]      mag_s4;
	logic [SQ_LW-1:0]      lsq_s4;

	logic [SQ_RW-1:0]      root;
	logic [SB_W-1:0]       sq_sb;
	logic                  valid_s5;
	logic [2:0]            sgn_s5;
	logic [2:0][16:0]      mag_s5;
	logic [16:0]           len_s5;

	logic [RCP_QW-1:0]     recip;
	logic [SB_W-1:0]       rcp_sb;
	logic                  rcp_valid;
	logic [2:0]            rcp_sgn;
	logic [2:0][16:0]      rcp_mag;

	logic                  valid_s6;
	logic [2:0]            sgn_s6;
	logic [2:0][16:0]      unit_s6;
	logic [47:0]           prod [0:2];

	logic [7:0]            byte_c [0:2];
	logic                  valid_s7;
	nct_pkg::texel_rgba_t  rgba_s7;

	// config channel and request channel never hold off
	assign cfg_ready = 1'b1;
	assign busy      = 1'b0;

	// hold the face edge register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			face_edge_q <= nct_pkg::EDGE_RST;
		end else if (cfg_valid && cfg_ready) begin
			face_edge_q <= cfg_data;
		end
	end

	// clamp the edge to 1..MAX_EDGE and positions below the edge
	always_comb begin
		if (face_edge_q == 11'd0) begin
			edge_c = EW'(1);
		end else if (32'(face_edge_q) > MAX_EDGE) begin
			edge_c = EW'(MAX_EDGE);
		end else begin
			edge_c = EW'(face_edge_q);
		end
		col_c = (32'(req.texel_col) >= 32'(edge_c)) ? 10'(edge_c - EW'(1)) : req.texel_col;
		row_c = (32'(req.texel_row) >= 32'(edge_c)) ? 10'(edge_c - EW'(1)) : req.texel_row;
	end

	// stage 1: form the texel center numerators (2p+1)<<16
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		face_s1  <= req.cube_face;
		num_u_s1 <= {col_c, 1'b1, 16'h0000};
		num_v_s1 <= {row_c, 1'b1, 16'h0000};
	end

	nct_div #(.NW(DIV_NW), .DW(EW), .QW(DIV_QW)) u_div_u (
		.clk (clk),
		.num (num_u_s1),
		.den (edge_c),
		.quo (t_u)
	);

	nct_div #(.NW(DIV_NW), .DW(EW), .QW(DIV_QW)) u_div_v (
		.clk (clk),
		.num (num_v_s1),
		.den (edge_c),
		.quo (t_v)
	);

	nct_dly #(.W(4), .DEPTH(DIV_QW)) u_dly_div (
		.clk    (clk),
		.arst_n (arst_n),
		.d      ({valid_s1, face_s1}),
		.q      ({div_valid, div_face})
	);

	// build the face direction from u and v
	always_comb begin
		u = $signed({1'b0, t_u}) - 19'sh10000;
		v = $signed({1'b0, t_v}) - 19'sh10000;
		unique case (div_face)
			nct_pkg::FACE_POS_X: begin
				dir[0] = 19'sh10000; dir[1] = -v; dir[2] = -u;
			end
			nct_pkg::FACE_NEG_X: begin
				dir[0] = -19'sh10000; dir[1] = -v; dir[2] = u;
			end
			nct_pkg::FACE_POS_Y: begin
				dir[0] = u; dir[1] = 19'sh10000; dir[2] = v;
			end
			nct_pkg::FACE_NEG_Y: begin
				dir[0] = u; dir[1] = -19'sh10000; dir[2] = -v;
			end
			nct_pkg::FACE_POS_Z: begin
				dir[0] = u; dir[1] = -v; dir[2] = 19'sh10000;
			end
			nct_pkg::FACE_NEG_Z: begin
				dir[0] = -u; dir[1] = -v; dir[2] = -19'sh10000;
			end
			default: begin
				dir[0] = '0; dir[1] = '0; dir[2] = '0;
			end
		endcase
	end

	// stages 2 to 4: sign and magnitude, squares, squared length
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s2 <= div_valid;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			sgn_s2[i] <= dir[i][18];
			mag_s2[i] <= dir[i][18] ? 17'(-dir[i]) : 17'(dir[i]);
			sq_s3[i]  <= 33'(mag_s2[i]) * 33'(mag_s2[i]);
		end
		sgn_s3 <= sgn_s2;
		mag_s3 <= mag_s2;
		sgn_s4 <= sgn_s3;
		mag_s4 <= mag_s3;
		lsq_s4 <= SQ_LW'(sq_s3[0]) + SQ_LW'(sq_s3[1]) + SQ_LW'(sq_s3[2]);
	end

	nct_sqrt #(.LW(SQ_LW)) u_sqrt (
		.clk  (clk),
		.rad  (lsq_s4),
		.root (root)
	);

	nct_dly #(.W(SB_W), .DEPTH(SQ_RW)) u_dly_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.d      ({valid_s4, sgn_s4, mag_s4}),
		.q      (sq_sb)
	);

	// stage 5: length; a zero vector takes length 17'h10000
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else begin
			valid_s5 <= sq_sb[SB_W-1];
		end
	end

	always_ff @(posedge clk) begin
		sgn_s5 <= sq_sb[SB_W-2 -: 3];
		mag_s5 <= sq_sb[50:0];
		len_s5 <= (root == '0) ? 17'h10000 : 17'(root);
	end

	nct_div #(.NW(RCP_NW), .DW(17), .QW(RCP_QW)) u_div_rcp (
		.clk (clk),
		.num (RCP_NW'(1) << 46),
		.den (len_s5),
		.quo (recip)
	);

	nct_dly #(.W(SB_W), .DEPTH(RCP_QW)) u_dly_rcp (
		.clk    (clk),
		.arst_n (arst_n),
		.d      ({valid_s5, sgn_s5, mag_s5}),
		.q      (rcp_sb)
	);

	assign rcp_valid = rcp_sb[SB_W-1];
	assign rcp_sgn   = rcp_sb[SB_W-2 -: 3];
	assign rcp_mag   = rcp_sb[50:0];

	// stage 6: scale each magnitude by the reciprocal length
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			prod[i] = 48'(rcp_mag[i]) * 48'(recip);
		end
	end

	// stage 7: bias and pack each component into a byte
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			logic [17:0] biased;
			logic [25:0] scaled;
			biased = sgn_s6[i] ? (18'h10000 - 18'(unit_s6[i]))
			                   : (18'h10000 + 18'(unit_s6[i]));
			scaled = {biased, 8'h00} - 26'(biased);
			byte_c[i] = scaled[24:17];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
		end else begin
			valid_s6 <= rcp_valid;
			valid_s7 <= valid_s6;
		end
	end

	always_ff @(posedge clk) begin
		sgn_s6 <= rcp_sgn;
		for (int i = 0; i < 3; i++) begin
			unit_s6[i] <= prod[i][46:30];
		end
		rgba_s7.red   <= byte_c[0];
		rgba_s7.green <= byte_c[1];
		rgba_s7.blue  <= byte_c[2];
		rgba_s7.alpha <= nct_pkg::ALPHA_ONE;
	end

	assign done   = valid_s7;
	assign result = rgba_s7;

endmodule
`default_nettype wire

[rtl/nct_chk.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// nct_chk
// Port-level checks for the normalization cube map texel generator.
// ----------------------------------------------------------------------------
module nct_chk (
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 start,
	input wire logic                 busy,
	input wire logic                 done,
	input wire nct_pkg::texel_rgba_t result,
	input wire logic                 cfg_ready
);

	// no result beat without a request beat exactly one latency earlier
	a_no_ghost: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(start && !busy, 73) |-> !done)
		else $error("result beat without a matching request");

	// every result carries an opaque alpha
	a_alpha: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.alpha == nct_pkg::ALPHA_ONE))
		else $error("alpha not opaque");

	// a unit vector cannot saturate all three channels
	a_unit: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(result.red == 8'hff && result.green == 8'hff && result.blue == 8'hff))
		else $error("direction not normalized");

	// both channels keep accepting every cycle
	a_open: assert property (@(posedge clk) disable iff (!arst_n)
		!busy && cfg_ready)
		else $error("channel held off");

endmodule

bind normalization_cubemap_texel nct_chk u_nct_chk (.*);
`default_nettype wire
